@@ design/imu_serial_frame_deframer_defines.svh @@
// ----------------------------------------------------------------------------
// IMU serial frame deframer - assertion macros
// Clocked checks on aclk, switched off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef IMU_SERIAL_FRAME_DEFRAMER_DEFINES_SVH
`define IMU_SERIAL_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset
`define IMUD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition leads to a consequence on the next edge
`define IMUD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`else

`define IMUD_ASSERT(lbl, prop, msg)
`define IMUD_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

@@ design/imud_pkg.sv @@
// ----------------------------------------------------------------------------
// IMU serial frame deframer - package
// Frame constants, operation codes and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package imud_pkg;

    // Frame markers
    localparam logic [7:0] HDR_BYTE  = 8'h55;
    localparam logic [7:0] FLAG_BYTE = 8'h61;

    // Frame lengths in bytes
    localparam int unsigned BASIC_LEN = 20;
    localparam int unsigned FULL_LEN  = 28;

    // Bytes 0 and 1 are markers and are not kept
    localparam int unsigned STORE_LEN = FULL_LEN - 2;
    localparam int unsigned IDX_W     = $clog2(STORE_LEN);
    localparam int unsigned POS_W     = $clog2(FULL_LEN);

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [IDX_W-1:0] idx_t;

    localparam pos_t POS_HDR   = pos_t'(0);
    localparam pos_t POS_FLAG  = pos_t'(1);
    localparam pos_t POS_DATA  = pos_t'(2);
    localparam pos_t POS_BASIC = pos_t'(BASIC_LEN);
    localparam pos_t POS_LAST  = pos_t'(FULL_LEN - 1);

    // Idle timeout register
    localparam logic [15:0] TIMEOUT_RESET = 16'd10;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic               time_valid;
        logic [63:0]        stamp_packed;
    } res_t;

endpackage

`default_nettype wire

@@ design/imu_serial_frame_deframer.sv @@
// A completed frame is registered into the output or the skid register. Throughput:
// one input word per cycle while the skid register is empty; the output register
// plus one skid register let a word be taken while a finished frame waits downstream.
// Reset: synchronous, active low; clears hunt position, idle count, valid
// flags and loads the idle timeout with 10 ticks. Frame bytes are not reset.
// ----------------------------------------------------------------------------
// IMU serial frame deframer
// Hunts for header and flag bytes, collects the motion payload and optional
// time bytes, and emits one decoded frame on completion or idle timeout.
// ----------------------------------------------------------------------------
`default_nettype none

`include "imu_serial_frame_deframer_defines.svh"

module imu_serial_frame_deframer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Configuration
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data,
    // Input words
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_operation,
    input  wire logic [7:0]         s_rx_byte,
    // Decoded frames
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_accel_x,
    output logic signed [15:0]      m_accel_y,
    output logic signed [15:0]      m_accel_z,
    output logic signed [15:0]      m_rate_x,
    output logic signed [15:0]      m_rate_y,
    output logic signed [15:0]      m_rate_z,
    output logic signed [15:0]      m_roll_angle,
    output logic signed [15:0]      m_pitch_angle,
    output logic signed [15:0]      m_yaw_angle,
    output logic                    m_time_valid,
    output logic [63:0]             m_stamp_packed
);

    logic [15:0]        timeout_reg;
    imud_pkg::pos_t     pos_reg, pos_next;
    logic [15:0]        idle_reg, idle_next;
    logic [7:0]         frame_reg [imud_pkg::STORE_LEN];

    imud_pkg::res_t     out_reg, skid_reg, res_new;
    logic               m_valid_reg, skid_valid_reg;

    logic               in_fire, out_fire;
    logic               store_we;
    imud_pkg::idx_t     store_idx;
    logic               res_fire;
    logic               res_with_time;
    imud_pkg::op_t      op;

    assign op       = imud_pkg::op_t'(s_operation);
    assign s_ready  = !skid_valid_reg;
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid_reg && m_ready;
    assign store_idx = imud_pkg::idx_t'(pos_reg - imud_pkg::POS_DATA);

    // Hold the idle timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= imud_pkg::TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // Advance the hunt and the idle counter
    always_comb begin
        pos_next      = pos_reg;
        idle_next     = idle_reg;
        store_we      = 1'b0;
        res_fire      = 1'b0;
        res_with_time = 1'b0;
        if (in_fire) begin
            unique case (op)
                imud_pkg::OP_TICK: begin
                    if (idle_reg != imud_pkg::IDLE_MAX) begin
                        idle_next = idle_reg + 16'd1;
                    end
                    if (pos_reg == imud_pkg::POS_BASIC && idle_next > timeout_reg) begin
                        pos_next = imud_pkg::POS_HDR;
                        res_fire = 1'b1;
                    end
                end
                imud_pkg::OP_BYTE: begin
                    idle_next = '0;
                    priority if (pos_reg == imud_pkg::POS_HDR
                                 && s_rx_byte == imud_pkg::HDR_BYTE) begin
                        pos_next = imud_pkg::POS_FLAG;
                    end else if (pos_reg == imud_pkg::POS_FLAG
                                 && s_rx_byte == imud_pkg::FLAG_BYTE) begin
                        pos_next = imud_pkg::POS_DATA;
                    end else if (pos_reg >= imud_pkg::POS_DATA
                                 && pos_reg <= imud_pkg::POS_LAST) begin
                        store_we = 1'b1;
                        if (pos_reg == imud_pkg::POS_LAST) begin
                            pos_next      = imud_pkg::POS_HDR;
                            res_fire      = 1'b1;
                            res_with_time = 1'b1;
                        end else begin
                            pos_next = pos_reg + imud_pkg::pos_t'(1);
                        end
                    end else begin
                        // Drop the byte and restart the hunt
                        pos_next = imud_pkg::POS_HDR;
                    end
                end
                default: begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= imud_pkg::POS_HDR;
            idle_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            idle_reg <= idle_next;
        end
    end

    // Store frame bytes from position 2 onwards
    always_ff @(posedge aclk) begin
        if (store_we) begin
            frame_reg[store_idx] <= s_rx_byte;
        end
    end

    // Build the result; the last time byte is taken straight from the input
    always_comb begin
        res_new.accel_x     = {frame_reg[1],  frame_reg[0]};
        res_new.accel_y     = {frame_reg[3],  frame_reg[2]};
        res_new.accel_z     = {frame_reg[5],  frame_reg[4]};
        res_new.rate_x      = {frame_reg[7],  frame_reg[6]};
        res_new.rate_y      = {frame_reg[9],  frame_reg[8]};
        res_new.rate_z      = {frame_reg[11], frame_reg[10]};
        res_new.roll_angle  = {frame_reg[13], frame_reg[12]};
        res_new.pitch_angle = {frame_reg[15], frame_reg[14]};
        res_new.yaw_angle   = {frame_reg[17], frame_reg[16]};
        res_new.time_valid  = res_with_time;
        if (res_with_time) begin
            res_new.stamp_packed = {frame_reg[18], frame_reg[19], frame_reg[20],
                                    frame_reg[21], frame_reg[22], frame_reg[23],
                                    s_rx_byte, frame_reg[24]};
        end else begin
            res_new.stamp_packed = '0;
        end
    end

    // Output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (res_fire) begin
            if (!m_valid_reg || out_fire) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_reg <= skid_reg;
            end
        end else if (res_fire) begin
            if (!m_valid_reg || out_fire) begin
                out_reg <= res_new;
            end else begin
                skid_reg <= res_new;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_accel_x      = out_reg.accel_x;
    assign m_accel_y      = out_reg.accel_y;
    assign m_accel_z      = out_reg.accel_z;
    assign m_rate_x       = out_reg.rate_x;
    assign m_rate_y       = out_reg.rate_y;
    assign m_rate_z       = out_reg.rate_z;
    assign m_roll_angle   = out_reg.roll_angle;
    assign m_pitch_angle  = out_reg.pitch_angle;
    assign m_yaw_angle    = out_reg.yaw_angle;
    assign m_time_valid   = out_reg.time_valid;
    assign m_stamp_packed = out_reg.stamp_packed;

    // Checks
    `IMUD_ASSERT(a_skid_behind_out, !skid_valid_reg || m_valid_reg, "skid word without output word")
    `IMUD_ASSERT(a_pos_in_frame, pos_reg <= imud_pkg::POS_LAST, "hunt position beyond frame")
    `IMUD_ASSERT_NEXT(a_emit_restarts, res_fire, pos_reg == imud_pkg::POS_HDR, "hunt not restarted")
    `IMUD_ASSERT(a_no_time_zero_stamp, !m_valid_reg || m_time_valid || m_stamp_packed == 64'd0, "stamp set without time")

endmodule

`default_nettype wire

@@ test/imu_serial_frame_deframer_test.sv @@
// ----------------------------------------------------------------------------
// IMU serial frame deframer - testbench
// Streams serial bytes and timer ticks through the deframer under random
// source gaps and sink stalls. A scoreboard rebuilds each frame from the
// accepted words and checks every decoded frame, field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_serial_frame_deframer_test;

    localparam int unsigned RANDOM_WORDS   = 950;
    localparam int unsigned PHASE_WORDS    = 200;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned HOLD_TICKS     = 60;
    localparam int unsigned NUM_FIELDS     = 11;
    localparam int unsigned REPORT_LIMIT   = 10;

    typedef logic [63:0] field_row_t [NUM_FIELDS];

    typedef enum int unsigned {
        SINK_OPEN,
        SINK_COIN,
        SINK_EVERY_THIRD,
        SINK_TRICKLE
    } sink_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: frame rebuilder and in-order checker
    // ------------------------------------------------------------------------
    class deframe_scoreboard;
        logic [7:0]        frame_bytes [imud_pkg::FULL_LEN];
        int unsigned       position;
        logic [15:0]       idle_ticks;
        logic [15:0]       timeout_ticks;
        imud_pkg::res_t    pending_frames [$];
        int unsigned       frames_predicted;
        int unsigned       frames_checked;
        int unsigned       mismatches;
        string             field_names [NUM_FIELDS] = '{
            "accel_x", "accel_y", "accel_z", "rate_x", "rate_y", "rate_z",
            "roll_angle", "pitch_angle", "yaw_angle", "time_valid", "stamp_packed"
        };

        function new();
            foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
            position         = 0;
            idle_ticks       = '0;
            timeout_ticks    = imud_pkg::TIMEOUT_RESET;
            frames_predicted = 0;
            frames_checked   = 0;
            mismatches       = 0;
        endfunction

        // Build the decoded frame from the collected bytes
        function imud_pkg::res_t decode_frame(bit with_time);
            imud_pkg::res_t f;
            f.accel_x     = {frame_bytes[3],  frame_bytes[2]};
            f.accel_y     = {frame_bytes[5],  frame_bytes[4]};
            f.accel_z     = {frame_bytes[7],  frame_bytes[6]};
            f.rate_x      = {frame_bytes[9],  frame_bytes[8]};
            f.rate_y      = {frame_bytes[11], frame_bytes[10]};
            f.rate_z      = {frame_bytes[13], frame_bytes[12]};
            f.roll_angle  = {frame_bytes[15], frame_bytes[14]};
            f.pitch_angle = {frame_bytes[17], frame_bytes[16]};
            f.yaw_angle   = {frame_bytes[19], frame_bytes[18]};
            f.time_valid  = with_time;
            if (with_time) begin
                f.stamp_packed = {frame_bytes[20], frame_bytes[21], frame_bytes[22],
                                  frame_bytes[23], frame_bytes[24], frame_bytes[25],
                                  frame_bytes[27], frame_bytes[26]};
            end else begin
                f.stamp_packed = '0;
            end
            return f;
        endfunction

        function void queue_frame(bit with_time);
            position = 0;
            pending_frames.push_back(decode_frame(with_time));
            frames_predicted++;
        endfunction

        // Advance the hunt and collection state by one accepted word
        function void note_word(imud_pkg::op_t op, logic [7:0] rx);
            if (op == imud_pkg::OP_TICK) begin
                if (idle_ticks != imud_pkg::IDLE_MAX) idle_ticks++;
                if (position == imud_pkg::BASIC_LEN && idle_ticks > timeout_ticks) begin
                    queue_frame(1'b0);
                end
            end else begin
                idle_ticks = '0;
                if (position == 0 && rx == imud_pkg::HDR_BYTE) begin
                    frame_bytes[0] = rx;
                    position = 1;
                end else if (position == 1 && rx == imud_pkg::FLAG_BYTE) begin
                    frame_bytes[1] = rx;
                    position = 2;
                end else if (position >= 2 && position < imud_pkg::FULL_LEN) begin
                    frame_bytes[position] = rx;
                    position++;
                    if (position == imud_pkg::FULL_LEN) queue_frame(1'b1);
                end else begin
                    position = 0;
                end
            end
        endfunction

        function field_row_t split_frame(imud_pkg::res_t f);
            field_row_t row;
            row[0]  = {48'd0, f.accel_x};
            row[1]  = {48'd0, f.accel_y};
            row[2]  = {48'd0, f.accel_z};
            row[3]  = {48'd0, f.rate_x};
            row[4]  = {48'd0, f.rate_y};
            row[5]  = {48'd0, f.rate_z};
            row[6]  = {48'd0, f.roll_angle};
            row[7]  = {48'd0, f.pitch_angle};
            row[8]  = {48'd0, f.yaw_angle};
            row[9]  = {63'd0, f.time_valid};
            row[10] = f.stamp_packed;
            return row;
        endfunction

        // Compare one decoded frame against the oldest expectation
        function void check_frame(imud_pkg::res_t got);
            imud_pkg::res_t want;
            field_row_t     want_row;
            field_row_t     got_row;
            bit             bad;
            if (pending_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("frame %0d: unexpected frame, none pending", frames_checked);
            end else begin
                want     = pending_frames.pop_front();
                want_row = split_frame(want);
                got_row  = split_frame(got);
                bad      = 1'b0;
                for (int i = 0; i < NUM_FIELDS; i++) begin
                    if (want_row[i] !== got_row[i]) begin
                        if (!bad) mismatches++;
                        bad = 1'b1;
                        if (mismatches <= REPORT_LIMIT)
                            $display("frame %0d %s: expected %h, actual %h", frames_checked,
                                     field_names[i], want_row[i], got_row[i]);
                    end
                end
            end
            frames_checked++;
        endfunction

        function int unsigned pending_count();
            return pending_frames.size();
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [15:0]  cfg_wr_data;
    logic         s_valid;
    logic         s_ready;
    logic         s_operation;
    logic [7:0]   s_rx_byte;
    logic         m_valid;
    logic         m_ready;
    logic signed [15:0] m_accel_x;
    logic signed [15:0] m_accel_y;
    logic signed [15:0] m_accel_z;
    logic signed [15:0] m_rate_x;
    logic signed [15:0] m_rate_y;
    logic signed [15:0] m_rate_z;
    logic signed [15:0] m_roll_angle;
    logic signed [15:0] m_pitch_angle;
    logic signed [15:0] m_yaw_angle;
    logic         m_time_valid;
    logic [63:0]  m_stamp_packed;

    deframe_scoreboard sb = new();

    bit           pace_gaps;
    int unsigned  burst_left;
    int unsigned  words_sent;
    logic [15:0]  timeout_now;

    imu_serial_frame_deframer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_accel_x      (m_accel_x),
        .m_accel_y      (m_accel_y),
        .m_accel_z      (m_accel_z),
        .m_rate_x       (m_rate_x),
        .m_rate_y       (m_rate_y),
        .m_rate_z       (m_rate_z),
        .m_roll_angle   (m_roll_angle),
        .m_pitch_angle  (m_pitch_angle),
        .m_yaw_angle    (m_yaw_angle),
        .m_time_valid   (m_time_valid),
        .m_stamp_packed (m_stamp_packed)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop if the run hangs
    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

    // Observe both handshakes on the clock edge
    always @(posedge aclk) begin
        imud_pkg::res_t got;
        if (aresetn && m_valid && m_ready) begin
            got.accel_x      = m_accel_x;
            got.accel_y      = m_accel_y;
            got.accel_z      = m_accel_z;
            got.rate_x       = m_rate_x;
            got.rate_y       = m_rate_y;
            got.rate_z       = m_rate_z;
            got.roll_angle   = m_roll_angle;
            got.pitch_angle  = m_pitch_angle;
            got.yaw_angle    = m_yaw_angle;
            got.time_valid   = m_time_valid;
            got.stamp_packed = m_stamp_packed;
            sb.check_frame(got);
        end
        if (aresetn && s_valid && s_ready)
            sb.note_word(imud_pkg::op_t'(s_operation), s_rx_byte);
    end

    // Sink pacing: stretches of varied stall patterns, plus long hold-offs
    initial begin : sink_pacing
        sink_mode_t  mode;
        int unsigned stretch;
        int unsigned next_hold_at;
        m_ready <= 1'b0;
        next_hold_at = 12;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            mode    = sink_mode_t'($urandom_range(0, 3));
            stretch = $urandom_range(8, 60);
            for (int k = 0; k < stretch; k++) begin
                case (mode)
                    SINK_OPEN:        m_ready <= 1'b1;
                    SINK_COIN:        m_ready <= ($urandom_range(0, 1) == 1);
                    SINK_EVERY_THIRD: m_ready <= (k % 3 == 2);
                    default:          m_ready <= ($urandom_range(0, 7) == 0);
                endcase
                @(posedge aclk);
            end
            // Hold off long enough for the block to back up into its input
            if (sb.frames_checked >= next_hold_at && next_hold_at <= 40) begin
                m_ready <= 1'b0;
                for (int k = 0; k < LONG_HOLD; k++) @(posedge aclk);
                next_hold_at += 20;
            end
        end
    end

    // Offer one word and hold it until taken; insert a gap at burst ends
    task automatic send_word(imud_pkg::op_t op, logic [7:0] rx);
        int unsigned gap;
        s_valid     <= 1'b1;
        s_operation <= op;
        s_rx_byte   <= rx;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (pace_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16)
                                                  : $urandom_range(1, 3);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_byte(logic [7:0] rx);
        send_word(imud_pkg::OP_BYTE, rx);
    endtask

    task automatic send_ticks(int unsigned n);
        repeat (n) send_word(imud_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_header();
        send_byte(imud_pkg::HDR_BYTE);
        send_byte(imud_pkg::FLAG_BYTE);
    endtask

    // Bias payload towards the extremes of a signed word
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_payload(int unsigned n);
        repeat (n) send_byte(pick_byte());
    endtask

    // Drop valid, let the last accepted word reach the scoreboard, then wait
    // for every pending frame and an empty output
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_count() != 0 || m_valid) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timeout(logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.timeout_ticks = value;
        timeout_now      = value;
    endtask

    // One randomly shaped frame or stretch of line noise
    task automatic random_frame();
        int unsigned pick;
        logic [7:0]  rx;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            // Full frame, occasionally paused mid-way
            send_header();
            for (int pos = 2; pos < imud_pkg::FULL_LEN; pos++) begin
                if (pos != imud_pkg::BASIC_LEN && $urandom_range(0, 15) == 0)
                    send_ticks($urandom_range(1, 4));
                if (pos > imud_pkg::BASIC_LEN && $urandom_range(0, 19) == 0)
                    send_ticks(timeout_now + $urandom_range(1, 5));
                send_byte(pick_byte());
            end
        end else if (pick < 75) begin
            // Basic frame released by the idle timeout
            send_header();
            send_payload(imud_pkg::BASIC_LEN - 2);
            send_ticks(timeout_now + 1 + $urandom_range(0, 3));
        end else if (pick < 85) begin
            // Basic frame that picks up its time bytes before the timeout
            send_header();
            send_payload(imud_pkg::BASIC_LEN - 2);
            send_ticks($urandom_range(0, timeout_now));
            send_payload(imud_pkg::FULL_LEN - imud_pkg::BASIC_LEN);
        end else if (pick < 93) begin
            // Line noise around the markers
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 3))
                    0:       send_ticks(1);
                    1:       send_byte(imud_pkg::HDR_BYTE);
                    2:       send_byte(imud_pkg::FLAG_BYTE);
                    default: send_byte(8'($urandom_range(0, 255)));
                endcase
            end
        end else if (pick < 97) begin
            // Header followed by a wrong flag
            rx = 8'($urandom_range(0, 255));
            if (rx == imud_pkg::FLAG_BYTE) rx = 8'h60;
            send_byte(imud_pkg::HDR_BYTE);
            send_byte(rx);
        end else begin
            // Frame cut short; the next frame's bytes run into it
            send_header();
            send_payload($urandom_range(0, imud_pkg::BASIC_LEN - 3));
        end
    endtask

    initial begin : stimulus
        logic [15:0] settings [6];
        int unsigned base_words;
        int unsigned phase_start;
        int unsigned phase;

        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_operation <= imud_pkg::OP_BYTE;
        s_rx_byte   <= '0;
        pace_gaps   = 1'b1;
        burst_left  = 0;
        words_sent  = 0;
        timeout_now = imud_pkg::TIMEOUT_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Hunt rejects: stray flag, repeated header, wrong flag, tick while hunting
        send_byte(imud_pkg::FLAG_BYTE);
        send_byte(imud_pkg::HDR_BYTE);
        send_byte(imud_pkg::HDR_BYTE);
        send_byte(imud_pkg::HDR_BYTE);
        send_byte(8'h00);
        send_ticks(1);

        // Full frame at the signed extremes with an all-ones timestamp
        send_header();
        for (int i = 0; i < imud_pkg::BASIC_LEN - 2; i++) begin
            case (i % 4)
                0: send_byte(8'h00);
                1: send_byte(8'h80);
                2: send_byte(8'hFF);
                default: send_byte(8'h7F);
            endcase
        end
        repeat (imud_pkg::FULL_LEN - imud_pkg::BASIC_LEN) send_byte(8'hFF);

        // Basic frame at the reset timeout: no release at equal, release one later
        send_header();
        send_payload(imud_pkg::BASIC_LEN - 2);
        send_ticks(imud_pkg::TIMEOUT_RESET);
        send_ticks(1);

        // Idle count cleared by a byte; a frame held past 20 bytes never times out
        send_header();
        send_payload(imud_pkg::BASIC_LEN - 2);
        send_ticks(5);
        send_payload(4);
        send_ticks(30);
        send_payload(imud_pkg::FULL_LEN - imud_pkg::BASIC_LEN - 4);
        settle();

        // Zero timeout: release on the first tick
        write_timeout(16'd0);
        send_header();
        send_payload(imud_pkg::BASIC_LEN - 2);
        send_ticks(1);
        settle();

        // Largest timeout holds the frame; a smaller one releases it on the next tick
        write_timeout(16'hFFFF);
        pace_gaps = 1'b0;
        send_header();
        send_payload(imud_pkg::BASIC_LEN - 2);
        send_ticks(HOLD_TICKS);
        settle();
        write_timeout(16'd20);
        send_ticks(1);
        settle();
        pace_gaps = 1'b1;

        // Random traffic in phases, one timeout setting per phase
        settings[0] = 16'd1;
        settings[1] = 16'd0;
        settings[2] = 16'd5;
        settings[3] = 16'd40;
        settings[4] = 16'd10;
        settings[5] = 16'd3;
        base_words  = words_sent;
        phase       = 0;
        write_timeout(settings[0]);
        phase_start = words_sent;
        while (words_sent - base_words < RANDOM_WORDS) begin
            random_frame();
            if (words_sent - phase_start >= PHASE_WORDS) begin
                settle();
                phase++;
                if (phase % 6 == 5)
                    write_timeout(16'($urandom_range(2, 30)));
                else
                    write_timeout(settings[phase % 6]);
                phase_start = words_sent;
            end
        end
        settle();

        if (sb.mismatches == 0 && sb.pending_count() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
